/* design/idc_pkg.sv */
`default_nettype none
package idc_pkg;

  localparam int LIST_SLOTS_DEF = 16;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [3:0]  IPV4_VERSION   = 4'd4;
  localparam logic [7:0]  LOOPBACK_OCTET = 8'h7F;
  localparam logic [15:0] PRIVATE_PREFIX = 16'hC0A8;
  localparam logic [31:0] LIMITED_BCAST  = 32'hFFFF_FFFF;
  localparam logic [7:0]  BCAST_OCTET    = 8'hFF;

  localparam logic [1:0] VERDICT_ACCEPT     = 2'd0;
  localparam logic [1:0] VERDICT_WAIT_GW    = 2'd1;
  localparam logic [1:0] VERDICT_WAIT_ROUTE = 2'd2;

  localparam logic [2:0] WHY_NOT_V4    = 3'd0;
  localparam logic [2:0] WHY_LOOPBACK  = 3'd1;
  localparam logic [2:0] WHY_WHITELIST = 3'd2;
  localparam logic [2:0] WHY_GATEWAY   = 3'd3;
  localparam logic [2:0] WHY_BROADCAST = 3'd4;
  localparam logic [2:0] WHY_ROUTE     = 3'd5;
  localparam logic [2:0] WHY_OTHER     = 3'd6;

  localparam logic CMD_CLASSIFY = 1'b0;
  localparam logic CMD_WRITE    = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [3:0]  ip_version;
    logic [31:0] dest_addr;
    logic        route_valid;
    logic        gateway_reachable;
    logic [3:0]  slot_index;
    logic [31:0] slot_addr;
    logic [31:0] slot_mask;
    logic        slot_valid;
  } in_t;

  typedef struct packed {
    logic [1:0] verdict;
    logic [2:0] reason;
    logic       refresh_route;
  } out_t;

  // decoded word handed from front to back
  typedef struct packed {
    logic        is_write;
    logic        early;      // alt result wins over a whitelist hit
    out_t        alt;        // result when the whitelist does not decide
    logic [31:0] dest_addr;
    logic [3:0]  slot_index;
    logic [31:0] slot_addr;
    logic [31:0] slot_mask;
    logic        slot_valid;
  } dec_t;

endpackage
`default_nettype wire

/* design/idc_front.sv */
`default_nettype none
module idc_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire idc_pkg::in_t  in_data,
  output logic               dec_valid,
  output idc_pkg::dec_t      dec_data,
  input  wire logic          dec_ready
);
  import idc_pkg::*;

  logic dec_valid_r, dec_valid_nxt;
  dec_t dec_r, dec_nxt;
  logic take;

  logic not_v4, loopback, gw_class, bcast;

  assign busy = dec_valid_r && !dec_ready;
  assign take = start && !busy;

  always_comb begin
    not_v4   = in_data.ip_version != IPV4_VERSION;
    loopback = in_data.dest_addr[31:24] == LOOPBACK_OCTET;
    gw_class = (in_data.dest_addr[31:16] != PRIVATE_PREFIX) &&
               (in_data.dest_addr != LIMITED_BCAST);
    bcast    = in_data.dest_addr[7:0] == BCAST_OCTET;

    dec_nxt.is_write   = in_data.cmd == CMD_WRITE;
    dec_nxt.dest_addr  = in_data.dest_addr;
    dec_nxt.slot_index = in_data.slot_index;
    dec_nxt.slot_addr  = in_data.slot_addr;
    dec_nxt.slot_mask  = in_data.slot_mask;
    dec_nxt.slot_valid = in_data.slot_valid;
    dec_nxt.early      = 1'b1;
    dec_nxt.alt        = '{VERDICT_ACCEPT, WHY_OTHER, 1'b0};
    priority if (in_data.cmd == CMD_WRITE) begin
      dec_nxt.alt = '{VERDICT_ACCEPT, WHY_OTHER, 1'b0};
    end else if (not_v4) begin
      dec_nxt.alt = '{VERDICT_ACCEPT, WHY_NOT_V4, 1'b0};
    end else if (loopback) begin
      dec_nxt.alt = '{VERDICT_ACCEPT, WHY_LOOPBACK, 1'b0};
    end else begin
      dec_nxt.early = 1'b0;
      priority if (gw_class) begin
        dec_nxt.alt = '{(in_data.gateway_reachable ? VERDICT_ACCEPT : VERDICT_WAIT_GW),
                        WHY_GATEWAY, 1'b0};
      end else if (bcast) begin
        dec_nxt.alt = '{VERDICT_ACCEPT, WHY_BROADCAST, 1'b0};
      end else if (in_data.route_valid) begin
        dec_nxt.alt = '{VERDICT_ACCEPT, WHY_ROUTE, 1'b1};
      end else begin
        dec_nxt.alt = '{VERDICT_WAIT_ROUTE, WHY_OTHER, 1'b0};
      end
    end
  end

  assign dec_valid_nxt = take || busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_valid_r <= 1'b0;
    end else begin
      dec_valid_r <= dec_valid_nxt;
    end
    if (take) begin
      dec_r <= dec_nxt;
    end
  end

  assign dec_valid = dec_valid_r;
  assign dec_data  = dec_r;

endmodule
`default_nettype wire

/* design/idc_queue.sv */
`default_nettype none
module idc_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire idc_pkg::dec_t  push_data,
  output logic                pop_valid,
  input  wire logic           pop_ready,
  output idc_pkg::dec_t       pop_data
);
  import idc_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);

  dec_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign pop_valid  = count_r != '0;
  assign do_pop     = pop_valid && pop_ready;
  assign push_ready = (count_r != CNT_W'(QUEUE_DEPTH)) || do_pop;
  assign do_push    = push_valid && push_ready;
  assign pop_data   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

/* design/idc_back.sv */
`default_nettype none
module idc_back #(
  parameter int LIST_SLOTS = idc_pkg::LIST_SLOTS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           dec_valid,
  output logic                dec_ready,
  input  wire idc_pkg::dec_t  dec_data,
  output logic                out_valid,
  output idc_pkg::out_t       out_data
);
  import idc_pkg::*;

  logic [31:0]           list_addr_r [LIST_SLOTS];
  logic [31:0]           list_mask_r [LIST_SLOTS];
  logic [LIST_SLOTS-1:0] list_valid_r, list_valid_nxt;
  logic [LIST_SLOTS-1:0] slot_we, slot_hit;
  logic                  hit;
  logic                  out_valid_r;
  out_t                  out_r, out_nxt;

  // back end never stalls: results leave on a strobe
  assign dec_ready = 1'b1;

  always_comb begin
    for (int i = 0; i < LIST_SLOTS; i++) begin
      slot_we[i]  = dec_valid && dec_data.is_write &&
                    ({28'd0, dec_data.slot_index} == 32'(i));
      slot_hit[i] = list_valid_r[i] &&
                    ((dec_data.dest_addr & list_mask_r[i]) ==
                     (list_addr_r[i] & list_mask_r[i]));
    end
    hit = |slot_hit;
    list_valid_nxt = list_valid_r;
    for (int i = 0; i < LIST_SLOTS; i++) begin
      if (slot_we[i]) begin
        list_valid_nxt[i] = dec_data.slot_valid;
      end
    end
  end

  always_comb begin
    priority if (dec_data.early || !hit) begin
      out_nxt = dec_data.alt;
    end else begin
      out_nxt = '{VERDICT_ACCEPT, WHY_WHITELIST, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      list_valid_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      list_valid_r <= list_valid_nxt;
      out_valid_r  <= dec_valid;
    end
    for (int i = 0; i < LIST_SLOTS; i++) begin
      if (slot_we[i]) begin
        list_addr_r[i] <= dec_data.slot_addr;
        list_mask_r[i] <= dec_data.slot_mask;
      end
    end
    if (dec_valid) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

/* design/ipv4_destination_classifier_unit.sv */
`default_nettype none
// an accepted word passes the front register, the queue and the result register before its out_valid strobe
// throughput: one word per cycle; the front register, the queue and the result
// register each move one word a cycle, and the whitelist compare is one parallel pass
// reset: synchronous active-low rst_n empties the queue and clears every whitelist slot
// the receiver cannot stall, so busy stays low and results leave on a one-cycle strobe
module ipv4_destination_classifier_unit #(
  parameter int LIST_SLOTS = idc_pkg::LIST_SLOTS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire idc_pkg::in_t  in_data,
  output logic               out_valid,
  output idc_pkg::out_t      out_data
);
  import idc_pkg::*;

  // front to queue
  logic front_valid, front_ready;
  dec_t front_data;

  // queue to back
  logic back_valid, back_ready;
  dec_t back_data;

  // front end: decodes the command and settles every check except the whitelist
  idc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .dec_valid (front_valid),
    .dec_data  (front_data),
    .dec_ready (front_ready)
  );

  // short queue decouples decode from the whitelist stage
  idc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_data  (front_data),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_data   (back_data)
  );

  // back end: owns the whitelist, applies writes in order, picks the final result
  idc_back #(
    .LIST_SLOTS (LIST_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .dec_valid (back_valid),
    .dec_ready (back_ready),
    .dec_data  (back_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

/* dv/tb_top.sv */
module tb_top;
  import idc_pkg::*;

  localparam int SLOTS       = LIST_SLOTS_DEF;
  localparam int CYCLE_LIMIT = 100000;
  localparam int DRAIN_WAIT  = 8;  // result lands after the front, queue and result registers, leave slack

  // one pending word for the driver plus the idle odds it is sent under
  typedef struct {
    in_t         word;
    int unsigned gap_pct;
  } pending_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t  in_data = '0;
  logic out_valid;
  out_t out_data;

  pending_t    word_q[$];
  out_t        verdict_q[$];   // predicted results in issue order
  int unsigned words_sent = 0;
  int unsigned words_taken = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned failures = 0;
  int unsigned cycle_count = 0;
  int unsigned writes_taken = 0;
  int unsigned reason_hits[7];

  // predictor copy of the whitelist
  logic [31:0] wl_addr[SLOTS];
  logic [31:0] wl_mask[SLOTS];
  logic        wl_valid[SLOTS];

  // generator-side copy, used only to aim destinations at stored slots
  logic [31:0] aim_addr[SLOTS];
  logic [31:0] aim_mask[SLOTS];

  ipv4_destination_classifier_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // fully random word, every bit of every field free
  function automatic in_t noise_word();
    logic [127:0] raw;
    raw = {$urandom(), $urandom(), $urandom(), $urandom()};
    return raw[$bits(in_t)-1:0];
  endfunction

  // expected result of one accepted word; a write also updates the whitelist copy
  function automatic out_t classify_word(input in_t w);
    out_t r;
    logic hit;
    r.verdict       = VERDICT_ACCEPT;
    r.reason        = WHY_OTHER;
    r.refresh_route = 1'b0;
    if (w.cmd == CMD_WRITE) begin
      if (int'(w.slot_index) < SLOTS) begin
        wl_addr[w.slot_index]  = w.slot_addr;
        wl_mask[w.slot_index]  = w.slot_mask;
        wl_valid[w.slot_index] = w.slot_valid;
      end
      return r;
    end
    hit = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      // cleared slots never match, so an empty list matches nothing
      if (wl_valid[i] && ((w.dest_addr & wl_mask[i]) == (wl_addr[i] & wl_mask[i])))
        hit = 1'b1;
    end
    if (w.ip_version != IPV4_VERSION) begin
      r.reason = WHY_NOT_V4;
    end else if (w.dest_addr[31:24] == LOOPBACK_OCTET) begin
      r.reason = WHY_LOOPBACK;
    end else if (hit) begin
      r.reason = WHY_WHITELIST;
    end else if (w.dest_addr[31:16] != PRIVATE_PREFIX && w.dest_addr != LIMITED_BCAST) begin
      r.reason  = WHY_GATEWAY;
      r.verdict = w.gateway_reachable ? VERDICT_ACCEPT : VERDICT_WAIT_GW;
    end else if (w.dest_addr[7:0] == BCAST_OCTET) begin
      r.reason = WHY_BROADCAST;
    end else if (w.route_valid) begin
      r.reason        = WHY_ROUTE;
      r.refresh_route = 1'b1;
    end else begin
      r.verdict = VERDICT_WAIT_ROUTE;
    end
    return r;
  endfunction

  // queue a whitelist write, classify fields left random
  task automatic push_write(input logic [3:0] idx, input logic [31:0] addr,
                            input logic [31:0] mask, input logic vld,
                            input int unsigned gap);
    pending_t p;
    p.word            = noise_word();
    p.word.cmd        = CMD_WRITE;
    p.word.slot_index = idx;
    p.word.slot_addr  = addr;
    p.word.slot_mask  = mask;
    p.word.slot_valid = vld;
    p.gap_pct         = gap;
    aim_addr[idx]     = addr;
    aim_mask[idx]     = mask;
    word_q.push_back(p);
  endtask

  // queue a classify word, slot fields left random
  task automatic push_classify(input logic [3:0] ver, input logic [31:0] dst,
                               input logic rv, input logic gw, input int unsigned gap);
    pending_t p;
    p.word                   = noise_word();
    p.word.cmd               = CMD_CLASSIFY;
    p.word.ip_version        = ver;
    p.word.dest_addr         = dst;
    p.word.route_valid       = rv;
    p.word.gateway_reachable = gw;
    p.gap_pct                = gap;
    word_q.push_back(p);
  endtask

  // driver: holds a word until it is taken, then sends the next or idles
  always @(negedge clk) begin
    pending_t nxt;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || words_taken == words_sent) begin
      if (word_q.size() != 0 && $urandom_range(99) >= word_q[0].gap_pct) begin
        nxt = word_q.pop_front();
        in_data <= nxt.word;
        start <= 1'b1;
        words_sent = words_sent + 1;
      end else begin
        // idle cycle: junk on the bus must be ignored
        in_data <= noise_word();
        start <= 1'b0;
      end
    end
  end

  // accept side: predict each word taken at this edge
  always @(posedge clk) begin
    out_t exp_r;
    if (rst_n && start && !busy) begin
      exp_r = classify_word(in_data);
      verdict_q.push_back(exp_r);
      words_taken = words_taken + 1;
      if (in_data.cmd == CMD_WRITE)
        writes_taken = writes_taken + 1;
      else
        reason_hits[exp_r.reason] = reason_hits[exp_r.reason] + 1;
    end
  end

  // monitor: compare each strobed result with the oldest prediction
  always @(posedge clk) begin
    out_t exp_r;
    if (rst_n && out_valid === 1'b1) begin
      results_seen = results_seen + 1;
      if (verdict_q.size() == 0) begin
        failures = failures + 1;
        if (mismatches < 10)
          $display("result %0d with nothing pending: verdict %0d reason %0d refresh %0d",
                   results_seen, out_data.verdict, out_data.reason, out_data.refresh_route);
        mismatches = mismatches + 1;
      end else begin
        exp_r = verdict_q.pop_front();
        if (out_data.verdict !== exp_r.verdict || out_data.reason !== exp_r.reason ||
            out_data.refresh_route !== exp_r.refresh_route) begin
          failures = failures + 1;
          if (mismatches < 10)
            $display("result %0d mismatch: exp verdict %0d reason %0d refresh %0d, got %0d %0d %0d",
                     results_seen, exp_r.verdict, exp_r.reason, exp_r.refresh_route,
                     out_data.verdict, out_data.reason, out_data.refresh_route);
          mismatches = mismatches + 1;
        end
      end
    end
  end

  // run limit
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results pending", cycle_count, verdict_q.size());
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int unsigned phase_gap[4];
    int unsigned gap;
    int unsigned k;
    int unsigned n;
    logic [31:0] dst;
    logic [31:0] m;
    logic [31:0] a;
    logic [3:0]  ver;

    phase_gap[0] = 0;
    phase_gap[1] = 73;
    phase_gap[2] = 10;
    phase_gap[3] = 0;
    for (int i = 0; i < 7; i++) reason_hits[i] = 0;
    for (int i = 0; i < SLOTS; i++) begin
      wl_addr[i]  = '0;
      wl_mask[i]  = '0;
      wl_valid[i] = 1'b0;
      aim_addr[i] = '0;
      aim_mask[i] = '0;
    end

    // directed words, back to back
    // empty list must not match a private address
    push_classify(4'd4, 32'hC0A8_0101, 1'b0, 1'b0, 0);
    push_classify(4'd0, 32'h0000_0000, 1'b0, 1'b0, 0);
    push_classify(4'd15, 32'hFFFF_FFFF, 1'b1, 1'b1, 0);
    push_classify(4'd6, 32'h7F00_0001, 1'b0, 1'b0, 0);
    push_classify(4'd4, 32'h7F00_0001, 1'b0, 1'b0, 0);
    push_classify(4'd4, 32'h7FFF_FFFF, 1'b1, 1'b1, 0);
    push_classify(4'd4, 32'h0808_0808, 1'b0, 1'b1, 0);
    push_classify(4'd4, 32'h0808_0808, 1'b1, 1'b0, 0);
    // limited broadcast skips the gateway check and lands on broadcast
    push_classify(4'd4, 32'hFFFF_FFFF, 1'b0, 1'b0, 0);
    push_classify(4'd4, 32'hC0A8_01FF, 1'b0, 1'b0, 0);
    push_classify(4'd4, 32'hC0A8_0000, 1'b1, 1'b0, 0);
    push_classify(4'd4, 32'hC0A8_FFFE, 1'b0, 1'b1, 0);
    // prefix slot, then a hit right after the write
    push_write(4'd0, 32'h0A00_0000, 32'hFF00_0000, 1'b1, 0);
    push_classify(4'd4, 32'h0A01_0203, 1'b0, 1'b0, 0);
    push_classify(4'd4, 32'h0B00_0000, 1'b0, 1'b0, 0);
    push_write(4'd15, 32'hC0A8_0500, 32'hFFFF_FF00, 1'b1, 0);
    push_classify(4'd4, 32'hC0A8_0507, 1'b0, 1'b0, 0);
    // zero mask on a valid slot matches everything below loopback
    push_write(4'd3, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 0);
    push_classify(4'd4, 32'hC0A8_0909, 1'b0, 1'b0, 0);
    push_classify(4'd4, 32'h7F12_3456, 1'b0, 1'b0, 0);
    push_classify(4'd5, 32'hC0A8_0909, 1'b0, 1'b0, 0);
    // clearing the slot stops the match
    push_write(4'd3, 32'h0000_0000, 32'h0000_0000, 1'b0, 0);
    push_classify(4'd4, 32'hC0A8_0909, 1'b0, 1'b0, 0);
    push_write(4'd15, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 0);
    push_classify(4'd4, 32'hC0A8_0507, 1'b1, 1'b0, 0);

    // random words in four pacing phases
    for (int p = 0; p < 4; p++) begin
      gap = phase_gap[p];
      for (int j = 0; j < 188; j++) begin
        if ($urandom_range(99) < 20) begin
          k = $urandom_range(SLOTS - 1);
          case ($urandom_range(3))
            0: a = {8'h0A, 8'($urandom_range(255, 0)), 16'h0};
            1: a = {16'hC0A8, 16'($urandom())};
            default: a = $urandom();
          endcase
          case ($urandom_range(39))
            0: m = 32'h0;
            1, 2, 3, 4: m = $urandom();
            default: begin
              n = $urandom_range(32, 8);
              m = 32'hFFFF_FFFF << (32 - n);
            end
          endcase
          push_write(k[3:0], a, m, $urandom_range(99) < 85, gap);
        end else begin
          k = $urandom_range(SLOTS - 1);
          case ($urandom_range(9))
            0: dst = {8'h7F, 24'($urandom())};
            1, 2: dst = {16'hC0A8, 16'($urandom())};
            3: dst = {16'hC0A8, 8'($urandom()), 8'hFF};
            4: dst = 32'hFFFF_FFFF;
            5, 6: begin
              dst = (aim_addr[k] & aim_mask[k]) | ($urandom() & ~aim_mask[k]);
              // near miss now and then
              if ($urandom_range(3) == 0) dst = dst ^ (32'h1 << $urandom_range(31));
            end
            7: dst = {24'($urandom()), 8'hFF};
            default: dst = $urandom();
          endcase
          ver = ($urandom_range(9) == 0) ? 4'($urandom()) : IPV4_VERSION;
          push_classify(ver, dst, 1'($urandom_range(1)), 1'($urandom_range(1)), gap);
        end
      end
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (word_q.size() != 0 || words_taken != words_sent || verdict_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (verdict_q.size() != 0) failures = failures + verdict_q.size();

    $display("covered %0d words: %0d whitelist writes, %0d classified, %0d results checked",
             words_taken, writes_taken, words_taken - writes_taken, results_seen);
    $display("reasons: notv4 %0d loop %0d wl %0d gw %0d bcast %0d route %0d other %0d, %0d bad",
             reason_hits[0], reason_hits[1], reason_hits[2], reason_hits[3],
             reason_hits[4], reason_hits[5], reason_hits[6], mismatches);
    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
design/idc_pkg.sv
design/idc_front.sv
design/idc_queue.sv
design/idc_back.sv
design/ipv4_destination_classifier_unit.sv
dv/tb_top.sv
